// ----- rtl/ilp_pkg.sv -----
// shared types, codes and character helpers for the integer literal parser
package ilp_pkg;

  localparam int INT_BITS_DEF = 64;
  localparam int VALUE_W      = 64;
  localparam int CH_W         = 8;
  localparam int STATUS_W     = 2;
  localparam int DIGIT_W      = 5;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_HEX,
    RX_OCT,
    RX_BIN
  } radix_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FMT = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  // input word
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last_char;
  } in_t;

  // output word
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } out_t;

  // per-literal control state
  typedef struct packed {
    phase_e phase;
    radix_e radix;
    logic   neg;
    logic   prev_us;
    logic   seen;
  } ctl_t;

  // result control travelling with the magnitude
  typedef struct packed {
    logic    neg;
    status_e status;
  } res_t;

  localparam ctl_t CTL_CLEAR = '{
    phase:   PH_START,
    radix:   RX_DEC,
    neg:     1'b0,
    prev_us: 1'b0,
    seen:    1'b0
  };

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_1     = 8'h31;
  localparam logic [CH_W-1:0] CH_7     = 8'h37;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_US    = 8'h5F;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LB    = 8'h62;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_LO    = 8'h6F;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'd16;
  localparam logic [DIGIT_W-1:0] DEC_MAX  = 5'd9;
  localparam logic [DIGIT_W-1:0] OCT_MAX  = 5'd7;
  localparam logic [DIGIT_W-1:0] BIN_MAX  = 5'd1;
  localparam logic [DIGIT_W-1:0] HEX_MAX  = 5'd15;

  // space, tab, newline, vertical tab, form feed, return
  function automatic logic is_ws(logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // hex digit value, NO_DIGIT when none
  function automatic logic [DIGIT_W-1:0] hex_value(logic [CH_W-1:0] c);
    logic [CH_W-1:0] v;
    v = CH_W'(NO_DIGIT);
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - (CH_LA - CH_W'(10));
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - (CH_UA - CH_W'(10));
    end
    return v[DIGIT_W-1:0];
  endfunction

endpackage

// ----- rtl/ilp_step.sv -----
// one-character parse step: next literal state and the result it ends with
module ilp_step #(
  parameter int INT_BITS = ilp_pkg::INT_BITS_DEF,
  parameter int BITS_W   = $clog2(INT_BITS + 5)
) (
  input  ilp_pkg::ctl_t                  ctl_i,
  input  logic [INT_BITS-1:0]            acc_i,
  input  logic [BITS_W-1:0]              bits_i,
  input  logic [ilp_pkg::CH_W-1:0]       ch_i,
  input  logic                           last_i,
  output ilp_pkg::ctl_t                  ctl_o,
  output logic [INT_BITS-1:0]            acc_o,
  output logic [BITS_W-1:0]              bits_o,
  output logic                           res_valid_o,
  output ilp_pkg::res_t                  res_o,
  output logic [INT_BITS-1:0]            res_mag_o
);
  import ilp_pkg::*;

  logic                   ws;
  logic                   is_19;
  logic [DIGIT_W-1:0]     hv;
  logic                   digit_ok;
  logic [INT_BITS:0]      limit;
  logic [INT_BITS+3:0]    dec_sum;
  logic                   dec_ovf;
  logic [INT_BITS-1:0]    pref_acc;
  logic [BITS_W-1:0]      pref_bits;
  logic                   pref_ovf;

  ctl_t                   upd_ctl;
  logic [INT_BITS-1:0]    upd_acc;
  logic [BITS_W-1:0]      upd_bits;
  status_e                st;
  logic                   fin;
  logic                   skip;
  logic                   take_digit;

  assign ws    = is_ws(ch_i);
  assign is_19 = (ch_i >= CH_1) && (ch_i <= CH_9);
  assign hv    = hex_value(ch_i);

  always_comb begin
    case (ctl_i.radix)
      RX_DEC:  digit_ok = (hv <= DEC_MAX);
      RX_OCT:  digit_ok = (hv <= OCT_MAX);
      RX_BIN:  digit_ok = (hv <= BIN_MAX);
      default: digit_ok = (hv <= HEX_MAX);
    endcase
  end

  // decimal: acc*10 + d against the signed range of the sign seen
  assign limit   = ((INT_BITS+1)'(1) << (INT_BITS - 1)) - (INT_BITS+1)'(!ctl_i.neg);
  assign dec_sum = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0}
                 + (INT_BITS+4)'(hv[3:0]);
  assign dec_ovf = (dec_sum > {3'b000, limit});

  // prefixed: shift in whole bits and count them
  always_comb begin
    case (ctl_i.radix)
      RX_HEX: begin
        pref_acc  = {acc_i[INT_BITS-5:0], hv[3:0]};
        pref_bits = bits_i + BITS_W'(4);
      end
      RX_OCT: begin
        pref_acc  = {acc_i[INT_BITS-4:0], hv[2:0]};
        pref_bits = bits_i + BITS_W'(3);
      end
      default: begin
        pref_acc  = {acc_i[INT_BITS-2:0], hv[0]};
        pref_bits = bits_i + BITS_W'(1);
      end
    endcase
  end
  assign pref_ovf = (pref_bits >= BITS_W'(INT_BITS));

  // decode the character against the current phase
  always_comb begin
    upd_ctl    = ctl_i;
    upd_acc    = acc_i;
    upd_bits   = bits_i;
    st         = ST_OK;
    fin        = 1'b0;
    skip       = 1'b0;
    take_digit = 1'b0;
    case (ctl_i.phase)
      PH_START: begin
        if (ws) begin
          skip = 1'b1;
        end else if (ch_i == CH_PLUS || ch_i == CH_MINUS) begin
          upd_ctl.neg   = (ch_i == CH_MINUS);
          upd_ctl.phase = PH_SIGNED;
        end else if (ch_i == CH_0) begin
          upd_ctl.phase = PH_ZERO;
        end else if (is_19) begin
          upd_ctl.radix = RX_DEC;
          upd_ctl.phase = PH_DIGITS;
          take_digit    = 1'b1;
        end else begin
          st = ST_FMT;
        end
      end
      PH_SIGNED: begin
        if (is_19) begin
          upd_ctl.radix = RX_DEC;
          upd_ctl.phase = PH_DIGITS;
          take_digit    = 1'b1;
        end else begin
          st = ST_FMT;
        end
      end
      PH_ZERO: begin
        if (ws) begin
          fin = 1'b1;
        end else if (ch_i == CH_LX) begin
          upd_ctl.radix = RX_HEX;
          upd_ctl.phase = PH_DIGITS;
        end else if (ch_i == CH_LO) begin
          upd_ctl.radix = RX_OCT;
          upd_ctl.phase = PH_DIGITS;
        end else if (ch_i == CH_LB) begin
          upd_ctl.radix = RX_BIN;
          upd_ctl.phase = PH_DIGITS;
        end else begin
          st = ST_FMT;
        end
      end
      PH_DIGITS: begin
        if (ws) begin
          fin = 1'b1;
        end else if (ch_i == CH_US) begin
          if (!ctl_i.seen || ctl_i.prev_us) begin
            st = ST_FMT;
          end else begin
            upd_ctl.prev_us = 1'b1;
          end
        end else if (digit_ok) begin
          take_digit = 1'b1;
        end else begin
          st = ST_FMT;
        end
      end
      default: begin
        skip = 1'b1;
      end
    endcase

    if (take_digit) begin
      upd_ctl.seen    = 1'b1;
      upd_ctl.prev_us = 1'b0;
      if (upd_ctl.radix == RX_DEC) begin
        if (dec_ovf) begin
          st = ST_OVF;
        end else begin
          upd_acc = dec_sum[INT_BITS-1:0];
        end
      end else begin
        upd_acc  = pref_acc;
        upd_bits = pref_bits;
        if (pref_ovf) begin
          st = ST_OVF;
        end
      end
    end
  end

  // next state
  always_comb begin
    ctl_o  = CTL_CLEAR;
    acc_o  = '0;
    bits_o = '0;
    if (skip) begin
      if (ctl_i.phase == PH_DISCARD && !(ws || last_i)) begin
        ctl_o  = ctl_i;
        acc_o  = acc_i;
        bits_o = bits_i;
      end
    end else if (st != ST_OK) begin
      if (!(ws || last_i)) begin
        ctl_o.phase = PH_DISCARD;
      end
    end else if (!(fin || last_i)) begin
      ctl_o  = upd_ctl;
      acc_o  = upd_acc;
      bits_o = upd_bits;
    end
  end

  // result
  always_comb begin
    res_valid_o = !skip && ((st != ST_OK) || fin || last_i);
    res_o       = '{neg: 1'b0, status: ST_FMT};
    res_mag_o   = '0;
    if (st != ST_OK) begin
      res_o.status = st;
    end else if (upd_ctl.phase == PH_ZERO) begin
      res_o.status = ST_OK;
    end else if (upd_ctl.phase == PH_DIGITS && upd_ctl.seen && !upd_ctl.prev_us) begin
      res_o     = '{neg: upd_ctl.neg, status: ST_OK};
      res_mag_o = upd_acc;
    end
  end

endmodule

// ----- rtl/integer_literal_parser_top.sv -----
// integer literal parser: character stream in, value and status out
//
//  channel  direction  handshake               word
//  in       input      in_valid_i/in_ready_o   in_data_i  (ch, last_char)
//  out      output     out_valid_o/out_ready_i out_data_o (value, status)
//
// one character is taken per cycle while in_ready_o is high; its result, if any,
// is registered in the main output slot, or in the skid slot while the main slot
// is held; the single decimal multiply-add and range compare sit between the
// literal state and the output slots. reset clears the literal state and both output slots
// a two-slot output (main register plus skid) keeps input flowing while a
// result waits; in_ready_o drops only while the skid slot is occupied
module integer_literal_parser_top #(
  parameter int INT_BITS = ilp_pkg::INT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ilp_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ilp_pkg::out_t out_data_o
);
  import ilp_pkg::*;

  localparam int BitsW = $clog2(INT_BITS + 5);

  // literal state
  ctl_t                ctl_q, ctl_d;
  logic [INT_BITS-1:0] acc_q, acc_d;
  logic [BitsW-1:0]    bits_q, bits_d;

  // result of the current character
  logic                res_valid;
  res_t                res;
  logic [INT_BITS-1:0] res_mag;

  // output slots
  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  res_t                out_res_q, out_res_d;
  res_t                skid_res_q, skid_res_d;
  logic [INT_BITS-1:0] out_mag_q, out_mag_d;
  logic [INT_BITS-1:0] skid_mag_q, skid_mag_d;

  logic                in_fire;
  logic                out_take;
  logic                new_res;
  logic [INT_BITS-1:0] signed_val;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;
  assign new_res    = in_fire && res_valid;

  ilp_step #(
    .INT_BITS (INT_BITS),
    .BITS_W   (BitsW)
  ) u_step (
    .ctl_i       (ctl_q),
    .acc_i       (acc_q),
    .bits_i      (bits_q),
    .ch_i        (in_data_i.ch),
    .last_i      (in_data_i.last_char),
    .ctl_o       (ctl_d),
    .acc_o       (acc_d),
    .bits_o      (bits_d),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_mag_o   (res_mag)
  );

  // literal state advances on each accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= CTL_CLEAR;
      acc_q  <= '0;
      bits_q <= '0;
    end else if (in_fire) begin
      ctl_q  <= ctl_d;
      acc_q  <= acc_d;
      bits_q <= bits_d;
    end
  end

  // output slot control: skid drains into main, else new result fills
  // main when it is free or being taken, else parks in the skid
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    out_mag_d    = out_mag_q;
    skid_res_d   = skid_res_q;
    skid_mag_d   = skid_mag_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_res_d    = skid_res_q;
        out_mag_d    = skid_mag_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_d = new_res;
      out_res_d   = res;
      out_mag_d   = res_mag;
    end else if (new_res) begin
      skid_valid_d = 1'b1;
      skid_res_d   = res;
      skid_mag_d   = res_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    out_mag_q  <= out_mag_d;
    skid_res_q <= skid_res_d;
    skid_mag_q <= skid_mag_d;
  end

  // magnitude and sign to two's complement, sign extended to the port
  assign signed_val        = out_res_q.neg ? (~out_mag_q + INT_BITS'(1)) : out_mag_q;
  assign out_valid_o       = out_valid_q;
  assign out_data_o.value  = VALUE_W'($signed(signed_val));
  assign out_data_o.status = out_res_q.status;

  // the skid slot is only ever occupied behind a held main slot
  a_skid_behind_main: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q
  ) else $error("skid slot valid with main slot empty");

  // the skid slot fills only when the main slot was stalled
  a_skid_fill_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i)
  ) else $error("skid slot filled without a stalled main slot");

  // any error result carries a zero value
  a_error_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> (out_data_o.value == '0)
  ) else $error("error result with non-zero value");

endmodule

// ----- dv/tb_top.sv -----
// testbench for the integer literal parser: directed rows, then random literals
`timescale 1ns / 1ps

module tb_top;
  import ilp_pkg::*;

  // parser width, the block is built with its default
  localparam int INT_W = INT_BITS_DEF;
  // words to push through in all, directed rows and whitespace included
  localparam int TOTAL_WORDS = 700;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_ready_i;
  out_t  out_data_o;

  integer_literal_parser_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // literal parser model: own copy of the per-literal state
  // ---------------------------------------------------------------------------
  phase_e      ph;
  radix_e      rdx;
  logic        neg;
  logic [63:0] mag;        // magnitude or raw prefixed bits
  logic [6:0]  nbits;      // bits taken by prefixed digits, wraps at 128
  logic        us_prev;    // last thing seen was an underscore
  logic        got_digit;

  // results still owed by the block, oldest first
  out_t parsed_q[$];

  function automatic void clear_lit();
    ph        = PH_START;
    rdx       = RX_DEC;
    neg       = 1'b0;
    mag       = '0;
    nbits     = '0;
    us_prev   = 1'b0;
    got_digit = 1'b0;
  endfunction

  // digit value in base 16, 16 when the character is no hex digit at all
  function automatic logic [4:0] digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  // fold one digit into the literal, gives the status it causes
  function automatic status_e take_digit(logic [4:0] d);
    logic [63:0] lim;
    int          w;
    got_digit = 1'b1;
    us_prev   = 1'b0;
    if (rdx == RX_DEC) begin
      // exact signed range: one more on the negative side
      lim = (64'd1 << (INT_W - 1)) - (neg ? 64'd0 : 64'd1);
      if (mag > (lim - 64'(d)) / 64'd10) return ST_OVF;
      mag = mag * 64'd10 + 64'(d);
      return ST_OK;
    end
    w     = (rdx == RX_HEX) ? 4 : (rdx == RX_OCT) ? 3 : 1;
    mag   = (mag << w) | 64'(d);
    nbits = nbits + 7'(w);
    // leading zero digits count towards the width too
    if (nbits >= INT_W) return ST_OVF;
    return ST_OK;
  endfunction

  // close the literal normally: lone zero, a complete number, or a format error
  function automatic logic end_lit(output out_t r);
    logic [63:0] v;
    int          sh;
    sh = 64 - INT_W;
    r  = '0;
    if (ph == PH_ZERO) begin
      r.status = ST_OK;
    end else if (ph == PH_DIGITS && got_digit && !us_prev) begin
      v        = neg ? (64'd0 - mag) : mag;
      r.value  = $signed(v << sh) >>> sh;
      r.status = ST_OK;
    end else begin
      r.status = ST_FMT;
    end
    clear_lit();
    return 1'b1;
  endfunction

  // one character through the model, 1 when it gives a result
  function automatic logic parse_char(logic [7:0] c, logic lst, output out_t r);
    logic       ws;
    status_e    st;
    logic [4:0] d;
    ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    st = ST_OK;
    r  = '0;
    case (ph)
      PH_START: begin
        if (ws) begin
          clear_lit();
          return 1'b0;
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          ph  = PH_SIGNED;
        end else if (c == CH_0) begin
          ph = PH_ZERO;
        end else if (c >= CH_1 && c <= CH_9) begin
          rdx = RX_DEC;
          ph  = PH_DIGITS;
          st  = take_digit(5'(c - CH_0));
        end else begin
          st = ST_FMT;
        end
      end
      PH_SIGNED: begin
        // a sign admits no leading zero and no prefix
        if (c >= CH_1 && c <= CH_9) begin
          rdx = RX_DEC;
          ph  = PH_DIGITS;
          st  = take_digit(5'(c - CH_0));
        end else begin
          st = ST_FMT;
        end
      end
      PH_ZERO: begin
        if (ws) return end_lit(r);
        if (c == CH_LX) begin
          rdx = RX_HEX;
          ph  = PH_DIGITS;
        end else if (c == CH_LO) begin
          rdx = RX_OCT;
          ph  = PH_DIGITS;
        end else if (c == CH_LB) begin
          rdx = RX_BIN;
          ph  = PH_DIGITS;
        end else begin
          st = ST_FMT;
        end
      end
      PH_DIGITS: begin
        if (ws) return end_lit(r);
        if (c == CH_US) begin
          // underscore only between two digits
          if (!got_digit || us_prev) st = ST_FMT;
          else us_prev = 1'b1;
        end else begin
          d = digit_of(c);
          if (rdx == RX_DEC && d > 5'd9) d = 5'd16;
          if (rdx == RX_OCT && d > 5'd7) d = 5'd16;
          if (rdx == RX_BIN && d > 5'd1) d = 5'd16;
          if (d > 5'd15) st = ST_FMT;
          else st = take_digit(d);
        end
      end
      default: begin
        // discarding the rest of a bad literal
        if (ws || lst) clear_lit();
        return 1'b0;
      end
    endcase
    if (st != ST_OK) begin
      clear_lit();
      // restart at once when the bad character also ended the literal
      if (!(ws || lst)) ph = PH_DISCARD;
      r.status = st;
      return 1'b1;
    end
    if (lst) return end_lit(r);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall pattern and checking
  // ---------------------------------------------------------------------------
  int   mismatches = 0;
  int   rx_mode = 0;
  int   rx_hold = 0;
  int   rx_tick = 0;
  out_t got_exp;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected word: value %0d status %0d", out_data_o.value, out_data_o.status);
        mismatches++;
      end else begin
        got_exp = parsed_q.pop_front();
        if (out_data_o.value !== got_exp.value) begin
          $error("value: expected %0d, got %0d", got_exp.value, out_data_o.value);
          mismatches++;
        end
        if (out_data_o.status !== got_exp.status) begin
          $error("status: expected %0d, got %0d", got_exp.status, out_data_o.status);
          mismatches++;
        end
      end
    end
    // rx_tick paces a fresh random draw of the stall style
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready_i <= 1'b1;                      // no stalls at all
      1: out_ready_i <= 1'($urandom_range(0, 1));  // coin toss
      2: out_ready_i <= (rx_tick % 5) != 0;        // regular short stalls
      default: begin
        // occasional long stalls so the skid slot fills and input backs up
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready_i <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_hold = $urandom_range(4, 24);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  int         burst_left;
  int         work_words;
  logic       typed_on;   // substitute the hand-written result for the model's
  out_t       typed_w;
  logic [7:0] lit_q[$];

  // one word, sender bursts with random gaps in between
  task automatic send_char(logic [7:0] c, logic lst);
    out_t r;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{ch: c, last_char: lst};
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    work_words++;
    if (parse_char(c, lst, r)) parsed_q.push_back(typed_on ? typed_w : r);
  endtask

  task automatic send_lit(logic mark_last);
    foreach (lit_q[i]) send_char(lit_q[i], mark_last && (i == lit_q.size() - 1));
  endtask

  // hold the input until every owed result is out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (parsed_q.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) lit_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] ws_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return 8'(CH_0 + v);
    return $urandom_range(0, 1) ? 8'(CH_UA + v - 10) : 8'(CH_LA + v - 10);
  endfunction

  // digits with the odd single underscore between them
  task automatic push_digits(int n, int base, logic nonzero_first);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 6) == 0) lit_q.push_back(CH_US);
      lit_q.push_back(digit_char((i == 0 && nonzero_first) ?
                                 $urandom_range(1, base - 1) : $urandom_range(0, base - 1)));
    end
  endtask

  task automatic build_dec();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      // the edges of the signed range
      case ($urandom_range(0, 3))
        0: push_text("9223372036854775807");
        1: push_text("9223372036854775808");
        2: push_text("-9223372036854775808");
        default: push_text("-9223372036854775809");
      endcase
    end else begin
      if ($urandom_range(0, 2) == 0) lit_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      push_digits((k < 5) ? $urandom_range(15, 20) : $urandom_range(1, 6), 10, 1'b1);
    end
  endtask

  task automatic build_prefixed();
    int w;
    int fit;
    lit_q.push_back(CH_0);
    case ($urandom_range(0, 2))
      0:       begin lit_q.push_back(CH_LX); w = 4; end
      1:       begin lit_q.push_back(CH_LO); w = 3; end
      default: begin lit_q.push_back(CH_LB); w = 1; end
    endcase
    // most digits that still fit below the width
    fit = (INT_W - 1) / w;
    push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(fit, fit + 2) :
                $urandom_range(1, (fit < 16) ? fit : 16), 1 << w, 1'b0);
  endtask

  // one random literal with its surroundings
  task automatic make_literal();
    int k;
    lit_q.delete();
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) lit_q.push_back(ws_char());
    k = $urandom_range(0, 99);
    if (k < 30) begin
      build_dec();
    end else if (k < 55) begin
      build_prefixed();
    end else if (k < 62) begin
      lit_q.push_back(CH_0);
    end else if (k < 82) begin
      // well-formed literal, then altered in one place, which mostly breaks it
      if ($urandom_range(0, 1)) build_dec();
      else build_prefixed();
      case ($urandom_range(0, 3))
        0: lit_q[$urandom_range(0, lit_q.size() - 1)] = 8'($urandom_range(0, 255));
        1: lit_q.insert($urandom_range(0, lit_q.size()), CH_US);
        2: lit_q.push_back(CH_US);
        default: lit_q.push_front($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      endcase
    end else begin
      // plain noise over the whole byte range
      repeat ($urandom_range(1, 6)) lit_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) begin
      send_lit(1'b1);
    end else begin
      repeat ($urandom_range(1, 2)) lit_q.push_back(ws_char());
      send_lit($urandom_range(0, 4) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed rows: text, mark the last character, result typed in or not
  // an empty text stands for a single nul character
  // ---------------------------------------------------------------------------
  typedef struct {
    string               txt;
    logic                mark_last;
    logic                typed;
    logic signed [63:0]  val;
    status_e             st;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    dir_rows = '{
      '{"",                      1'b1, 1'b1, 64'sd0,  ST_FMT},  // nul byte
      '{"\377 ",                 1'b0, 1'b1, 64'sd0,  ST_FMT},  // top byte
      '{" \t0\n",                1'b0, 1'b1, 64'sd0,  ST_OK},   // leading blanks, lone zero
      '{"0",                     1'b1, 1'b1, 64'sd0,  ST_OK},
      '{"+0 ",                   1'b0, 1'b1, 64'sd0,  ST_FMT},
      '{"-0",                    1'b1, 1'b1, 64'sd0,  ST_FMT},
      '{"01 ",                   1'b0, 1'b1, 64'sd0,  ST_FMT},
      '{"0_",                    1'b1, 1'b1, 64'sd0,  ST_FMT},
      '{"+",                     1'b1, 1'b1, 64'sd0,  ST_FMT},  // sign, no digits
      '{"0x ",                   1'b0, 1'b1, 64'sd0,  ST_FMT},  // prefix, no digits
      '{"1__2 ",                 1'b0, 1'b1, 64'sd0,  ST_FMT},
      '{"0x_f\r",                1'b0, 1'b1, 64'sd0,  ST_FMT},
      '{"12_\v",                 1'b0, 1'b1, 64'sd0,  ST_FMT},
      '{"1_000\f",               1'b0, 1'b1, 64'sd1000, ST_OK},
      '{"-42",                   1'b1, 1'b1, -64'sd42, ST_OK},
      '{"12a4 ",                 1'b0, 1'b1, 64'sd0,  ST_FMT},  // stray letter
      '{"0o78 ",                 1'b0, 1'b1, 64'sd0,  ST_FMT},
      '{"0b102",                 1'b1, 1'b1, 64'sd0,  ST_FMT},  // bad digit marked last
      '{"-0x1 ",                 1'b0, 1'b1, 64'sd0,  ST_FMT},  // sign before prefix
      '{"a5",                    1'b1, 1'b1, 64'sd0,  ST_FMT},  // last mark while discarding
      '{"9223372036854775807 ",  1'b0, 1'b1, 64'sh7FFF_FFFF_FFFF_FFFF, ST_OK},
      '{"-9223372036854775808",  1'b1, 1'b1, 64'sh8000_0000_0000_0000, ST_OK},
      '{"9223372036854775808 ",  1'b0, 1'b1, 64'sd0,  ST_OVF},
      '{"0xFFFFFFFFFFFFFFF ",    1'b0, 1'b1, 64'sh0FFF_FFFF_FFFF_FFFF, ST_OK},
      '{"0x0000000000000000 ",   1'b0, 1'b1, 64'sd0,  ST_OVF},  // 16 digits reach the width
      '{"0xdeadBEEF_01 0o17_7 ", 1'b0, 1'b0, 64'sd0,  ST_OK},
      '{" 0b1_0_1",              1'b1, 1'b0, 64'sd0,  ST_OK}
    };
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    rst_ni      <= 1'b0;
    burst_left  = 0;
    work_words  = 0;
    typed_on    = 1'b0;
    typed_w     = '0;
    clear_lit();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      lit_q.delete();
      if (dir_rows[i].txt.len() == 0) lit_q.push_back(8'h00);
      else push_text(dir_rows[i].txt);
      typed_on       = dir_rows[i].typed;
      typed_w.value  = dir_rows[i].val;
      typed_w.status = dir_rows[i].st;
      send_lit(dir_rows[i].mark_last);
    end
    typed_on = 1'b0;
    drain();

    // random literals, with one full drain half way through
    while (work_words < TOTAL_WORDS / 2) make_literal();
    drain();
    while (work_words < TOTAL_WORDS) make_literal();

    drain();
    repeat (20) @(posedge clk_i);
    if (parsed_q.size() != 0) begin
      $error("%0d results never arrived", parsed_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
